// ===== rtl/pwla_pkg.sv =====
package pwla_pkg;

	localparam int MAX_SEGMENTS = 128;
	localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
	localparam int SRCH_LVLS    = SEG_AW;
	localparam int CNT_W        = SEG_AW + 1;
	localparam int DIFF_W       = 33;
	localparam int PROD_W       = DIFF_W + 16;
	localparam int RAW_W        = PROD_W + 1;

	localparam logic [31:0] XBASE_MASK = 32'hFFFF_FFFC;

	localparam logic FUNC_ACT  = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	localparam logic REG_SEG_COUNT = 1'b0;
	localparam logic REG_OUT_WIDTH = 1'b1;

	localparam logic [1:0] OW_8  = 2'd0;
	localparam logic [1:0] OW_16 = 2'd1;

	localparam logic [1:0] SH_8  = 2'd0;
	localparam logic [1:0] SH_16 = 2'd1;
	localparam logic [1:0] SH_24 = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [31:0] x;
		logic               last;
		logic               low;
		logic [SEG_AW-1:0]  idx;
		logic [31:0]        xraw;
		logic signed [15:0] ybase;
		logic signed [15:0] slope;
	} item_t;

	function automatic logic signed [31:0] masked_base(input logic [31:0] xraw);
		masked_base = $signed(xraw & XBASE_MASK);
	endfunction

endpackage

// ===== rtl/pwla_level.sv =====
module pwla_level (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  pwla_pkg::item_t              in_item,
	input  logic [pwla_pkg::SEG_AW-1:0]  in_lo,
	input  logic [pwla_pkg::CNT_W-1:0]   in_hi,
	output logic                         out_vld,
	output pwla_pkg::item_t              out_item,
	output logic [pwla_pkg::SEG_AW-1:0]  out_lo,
	output logic [pwla_pkg::CNT_W-1:0]   out_hi
);
	import pwla_pkg::*;

	// one copy of the masked bases per search level
	logic signed [31:0] mem [MAX_SEGMENTS];

	logic [CNT_W-1:0]   sum;
	logic [SEG_AW-1:0]  mid;
	logic               vld_s1;
	item_t              item_s1;
	logic [SEG_AW-1:0]  lo_s1;
	logic [CNT_W-1:0]   hi_s1;
	logic [SEG_AW-1:0]  mid_s1;
	logic signed [31:0] rd_s1;
	logic [CNT_W-1:0]   lo_inc;
	logic               busy;

	assign sum = {1'b0, in_lo} + in_hi;
	assign mid = sum[CNT_W-1:1];

	always_ff @(posedge clk) begin
		if (en && in_vld) begin
			if (in_item.func == FUNC_LOAD) begin
				mem[in_item.idx] <= masked_base(in_item.xraw);
			end else begin
				rd_s1 <= mem[mid];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			lo_s1   <= in_lo;
			hi_s1   <= in_hi;
			mid_s1  <= mid;
		end
	end

	assign lo_inc = {1'b0, lo_s1} + CNT_W'(1);
	assign busy   = hi_s1 > lo_inc;

	always_comb begin
		out_lo = lo_s1;
		out_hi = hi_s1;
		if (busy) begin
			if (item_s1.x < rd_s1) begin
				out_hi = {1'b0, mid_s1};
			end else begin
				out_lo = mid_s1;
			end
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

// ===== rtl/pwla_arith.sv =====
module pwla_arith (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  pwla_pkg::item_t                    in_item,
	input  logic [pwla_pkg::SEG_AW-1:0]        in_lo,
	output logic                               out_vld,
	output logic signed [pwla_pkg::RAW_W-1:0]  out_raw,
	output logic                               out_last
);
	import pwla_pkg::*;

	// full entries for the chosen segment
	logic [63:0] mem [MAX_SEGMENTS];

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [63:0]        ent_s1;
	logic signed [31:0] x_s1;
	logic               last_s1, low_s1;
	logic signed [DIFF_W-1:0] diff_s2;
	logic [1:0]         sh_s2, sh_s3;
	logic signed [15:0] yb_s2, yb_s3, slope_s2;
	logic               last_s2, low_s2, last_s3, low_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [RAW_W-1:0]  raw_s4;
	logic               last_s4;
	logic signed [RAW_W-1:0]  prod_ext, shifted, raw_nx;

	always_ff @(posedge clk) begin
		if (en && in_vld) begin
			if (in_item.func == FUNC_LOAD) begin
				mem[in_item.idx] <= {in_item.xraw, in_item.ybase, in_item.slope};
			end else begin
				ent_s1 <= mem[in_lo];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld && (in_item.func == FUNC_ACT);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		prod_ext = RAW_W'(prod_s3);
		case (sh_s3)
			SH_8:    shifted = prod_ext >>> 8;
			SH_16:   shifted = prod_ext >>> 16;
			SH_24:   shifted = prod_ext >>> 24;
			default: shifted = prod_ext >>> 32;
		endcase
		if (low_s3) begin
			raw_nx = RAW_W'(yb_s3);
		end else begin
			raw_nx = shifted + RAW_W'(yb_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= in_item.x;
			last_s1  <= in_item.last;
			low_s1   <= in_item.low;
			diff_s2  <= DIFF_W'(x_s1) - DIFF_W'(masked_base(ent_s1[63:32]));
			sh_s2    <= ent_s1[33:32];
			yb_s2    <= ent_s1[31:16];
			slope_s2 <= ent_s1[15:0];
			last_s2  <= last_s1;
			low_s2   <= low_s1;
			prod_s3  <= diff_s2 * slope_s2;
			sh_s3    <= sh_s2;
			yb_s3    <= yb_s2;
			last_s3  <= last_s2;
			low_s3   <= low_s2;
			raw_s4   <= raw_nx;
			last_s4  <= last_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign out_raw  = raw_s4;
	assign out_last = last_s4;

endmodule

// ===== rtl/pwl_activation_unit.sv =====
// Piecewise-linear activation unit.
// Sample channel: sample_valid / sample_stall. func selects the item kind:
// an activate item maps sample through the segment table, a load item
// writes one table entry (seg_index, seg_xbase, seg_ybase, seg_slope) and
// yields no result. Result channel: result_valid / result_stall, carrying
// activation, saturated, saturation_total and last_out.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 writes
// segment_count, 1 writes output_width. Write only while the unit is idle.
// Pipeline: an accepted item passes 7 search levels, 4 arithmetic stages
// and 1 output register before its result is shown; one item per cycle is
// accepted when the receiver keeps up. The table search is a 7-level
// binary search, one level per stage, each level with its own copy of the
// bases; loads walk the same stages so order is kept.
// Stall: when a result waits under result_stall the whole pipeline holds
// and sample_stall rises; nothing is lost or repeated.
// Reset: pipeline emptied, saturation counter cleared, segment_count = 1,
// output_width = 16 bit. Table contents are undefined until loaded.
module pwl_activation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic        func,
	input  logic [31:0] sample,
	input  logic        last_in,
	input  logic [6:0]  seg_index,
	input  logic [31:0] seg_xbase,
	input  logic [15:0] seg_ybase,
	input  logic [15:0] seg_slope,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] activation,
	output logic        saturated,
	output logic [31:0] saturation_total,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import pwla_pkg::*;

	logic [7:0]         seg_cnt_q;
	logic [1:0]         out_w_q;
	logic [CNT_W-1:0]   cnt_eff;
	logic               en;
	logic [31:0]        e0_xraw_q;
	item_t              in_item;

	logic               lvl_vld  [SRCH_LVLS+1];
	item_t              lvl_item [SRCH_LVLS+1];
	logic [SEG_AW-1:0]  lvl_lo   [SRCH_LVLS+1];
	logic [CNT_W-1:0]   lvl_hi   [SRCH_LVLS+1];

	logic               ar_vld;
	logic signed [RAW_W-1:0] ar_raw;
	logic               ar_last;

	logic signed [RAW_W-1:0] lim_hi, lim_lo, clip;
	logic               sat;
	logic               out_vld_q;
	logic [31:0]        sat_cnt_q;
	logic [31:0]        act_q;
	logic               sat_q, last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q <= 8'd1;
			out_w_q   <= OW_16;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEG_COUNT: seg_cnt_q <= cfg_data;
				REG_OUT_WIDTH: out_w_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cnt_eff = (seg_cnt_q > 8'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
		: CNT_W'(seg_cnt_q);

	// whole pipeline holds while a result waits
	assign en           = !(out_vld_q && result_stall);
	assign sample_stall = !en;

	// entry 0 base, kept in order with the sample stream
	always_ff @(posedge clk) begin
		if (en && sample_valid && (func == FUNC_LOAD) && (seg_index == '0)) begin
			e0_xraw_q <= seg_xbase;
		end
	end

	always_comb begin
		in_item.func  = func;
		in_item.x     = $signed(sample);
		in_item.last  = last_in;
		in_item.low   = $signed(sample) <= masked_base(e0_xraw_q);
		in_item.idx   = seg_index;
		in_item.xraw  = seg_xbase;
		in_item.ybase = $signed(seg_ybase);
		in_item.slope = $signed(seg_slope);
	end

	// at or below segment 0: a one-wide range pins the search to entry 0
	assign lvl_vld[0]  = sample_valid;
	assign lvl_item[0] = in_item;
	assign lvl_lo[0]   = '0;
	assign lvl_hi[0]   = in_item.low ? CNT_W'(1) : cnt_eff;

	for (genvar k = 0; k < SRCH_LVLS; k++) begin : g_lvl
		pwla_level u_level (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (lvl_vld[k]),
			.in_item  (lvl_item[k]),
			.in_lo    (lvl_lo[k]),
			.in_hi    (lvl_hi[k]),
			.out_vld  (lvl_vld[k+1]),
			.out_item (lvl_item[k+1]),
			.out_lo   (lvl_lo[k+1]),
			.out_hi   (lvl_hi[k+1])
		);
	end

	pwla_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (lvl_vld[SRCH_LVLS]),
		.in_item  (lvl_item[SRCH_LVLS]),
		.in_lo    (lvl_lo[SRCH_LVLS]),
		.out_vld  (ar_vld),
		.out_raw  (ar_raw),
		.out_last (ar_last)
	);

	// clamp to the selected output width; width code 3 acts as 32 bit
	always_comb begin
		case (out_w_q)
			OW_8: begin
				lim_hi = RAW_W'(127);
				lim_lo = -RAW_W'(128);
			end
			OW_16: begin
				lim_hi = RAW_W'(32767);
				lim_lo = -RAW_W'(32768);
			end
			default: begin
				lim_hi = RAW_W'(64'sd2147483647);
				lim_lo = -RAW_W'(64'sd2147483648);
			end
		endcase
		sat  = 1'b0;
		clip = ar_raw;
		if (ar_raw > lim_hi) begin
			clip = lim_hi;
			sat  = 1'b1;
		end else if (ar_raw < lim_lo) begin
			clip = lim_lo;
			sat  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sat_cnt_q <= '0;
		end else if (en) begin
			out_vld_q <= ar_vld;
			if (ar_vld && sat) begin
				sat_cnt_q <= sat_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_q  <= clip[31:0];
			sat_q  <= sat;
			last_q <= ar_last;
		end
	end

	assign result_valid     = out_vld_q;
	assign activation       = act_q;
	assign saturated        = sat_q;
	assign saturation_total = sat_cnt_q;
	assign last_out         = last_q;

`ifndef NO_ASSERTIONS
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ar_vld && sat) |=> (sat_cnt_q == $past(sat_cnt_q) + 32'd1))
		else $error("saturation counter missed a clipped item");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && ar_vld && sat) |=> $stable(sat_cnt_q))
		else $error("saturation counter moved without a clipped item");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("input stalled with no waiting result");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pwla_pkg::*;

	// output width codes the package leaves unnamed
	localparam logic [1:0] OW_32   = 2'd2;
	localparam logic [1:0] OW_WIDE = 2'd3;  // reserved code, acts as 32 bit
	localparam int DRAIN_CYCLES = 16;       // longer than the pipeline depth

	typedef struct {
		logic [31:0] act;
		logic        sat;
		logic [31:0] total;
		logic        last;
	} act_result_t;

	// Activation predictor plus the queue of results it still waits for.
	class act_scoreboard;
		logic [31:0]        seg_x [MAX_SEGMENTS];
		logic signed [15:0] seg_y [MAX_SEGMENTS];
		logic signed [15:0] seg_m [MAX_SEGMENTS];
		logic [7:0]  seg_count;
		logic [1:0]  out_width;
		logic [31:0] sat_count;
		act_result_t pending [$];
		int errors;
		int results_seen;
		int sat_seen;

		function new();
			seg_count = 8'd1;
			out_width = OW_16;
			sat_count = '0;
			errors = 0;
			results_seen = 0;
			sat_seen = 0;
		endfunction

		function longint base_of(int k);
			logic signed [31:0] mb;
			mb = seg_x[k] & XBASE_MASK;
			return longint'(mb);
		endfunction

		function void note_item(logic fn, logic signed [31:0] smp, logic lst,
				logic [6:0] idx, logic [31:0] xb, logic signed [15:0] yb,
				logic signed [15:0] sl);
			longint x, raw, hi_lim, lo_lim;
			int cnt, lo, hi, mid;
			act_result_t r;
			if (fn == FUNC_LOAD) begin
				seg_x[idx] = xb;
				seg_y[idx] = yb;
				seg_m[idx] = sl;
				return;
			end
			x = longint'(smp);
			if (x <= base_of(0)) begin
				raw = longint'(seg_y[0]);
			end else begin
				cnt = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
				lo = 0;
				hi = cnt;
				while (hi > lo + 1) begin
					mid = (lo + hi) >> 1;
					if (x < base_of(mid))
						hi = mid;
					else
						lo = mid;
				end
				raw = (x - base_of(lo)) * longint'(seg_m[lo]);
				raw = raw >>> ((int'(seg_x[lo][1:0]) + 1) * 8);
				raw = raw + longint'(seg_y[lo]);
			end
			case (out_width)
				OW_8: begin
					hi_lim = 127;
					lo_lim = -128;
				end
				OW_16: begin
					hi_lim = 32767;
					lo_lim = -32768;
				end
				default: begin
					hi_lim = 64'sd2147483647;
					lo_lim = -64'sd2147483648;
				end
			endcase
			r.sat = 1'b0;
			if (raw > hi_lim) begin
				raw = hi_lim;
				r.sat = 1'b1;
			end else if (raw < lo_lim) begin
				raw = lo_lim;
				r.sat = 1'b1;
			end
			if (r.sat)
				sat_count = sat_count + 1;
			r.act = raw[31:0];
			r.total = sat_count;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] act, logic sat, logic [31:0] total,
				logic lst);
			act_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				$display("%t ERROR: result with none expected: act=%h sat=%b total=%0d",
					$time, act, sat, total);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (sat)
				sat_seen++;
			if (act !== e.act) begin
				$display("%t ERROR: activation exp %h got %h", $time, e.act, act);
				errors++;
			end
			if (sat !== e.sat) begin
				$display("%t ERROR: saturated exp %b got %b", $time, e.sat, sat);
				errors++;
			end
			if (total !== e.total) begin
				$display("%t ERROR: saturation_total exp %0d got %0d", $time, e.total, total);
				errors++;
			end
			if (lst !== e.last) begin
				$display("%t ERROR: last_out exp %b got %b", $time, e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	logic        func;
	logic [31:0] sample;
	logic        last_in;
	logic [6:0]  seg_index;
	logic [31:0] seg_xbase;
	logic [15:0] seg_ybase;
	logic [15:0] seg_slope;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] activation;
	logic        saturated;
	logic [31:0] saturation_total;
	logic        last_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	act_scoreboard sb;
	int send_idle_pct;     // chance of a sender gap after each item
	int recv_stall_pct;    // chance of result_stall per cycle
	int activations_sent;
	int loads_sent;

	pwl_activation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.func(func),
		.sample(sample),
		.last_in(last_in),
		.seg_index(seg_index),
		.seg_xbase(seg_xbase),
		.seg_ybase(seg_ybase),
		.seg_slope(seg_slope),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.activation(activation),
		.saturated(saturated),
		.saturation_total(saturation_total),
		.last_out(last_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop for a hung handshake
	initial begin
		#5ms;
		$display("timeout: %0d results still expected", sb.pending.size());
		$display("Simulation FAILED");
		$finish;
	end

	// receiver back-pressure, rate set per phase
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// result monitor: values seen here are the ones the block saw at this edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(activation, saturated, saturation_total, last_out);
	end

	// Push one item and hold it until accepted; the predictor sees it on accept.
	task automatic send_item(logic fn, logic [31:0] smp, logic lst, logic [6:0] idx,
			logic [31:0] xb, logic [15:0] yb, logic [15:0] sl);
		sample_valid <= 1'b1;
		func         <= fn;
		sample       <= smp;
		last_in      <= lst;
		seg_index    <= idx;
		seg_xbase    <= xb;
		seg_ybase    <= yb;
		seg_slope    <= sl;
		do
			@(posedge clk);
		while (sample_stall);
		sb.note_item(fn, smp, lst, idx, xb, yb, sl);
		if (fn == FUNC_LOAD)
			loads_sent++;
		else
			activations_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic activate(logic [31:0] smp);
		send_item(FUNC_ACT, smp, 1'($urandom_range(1)), 7'($urandom), $urandom,
			16'($urandom), 16'($urandom));
	endtask

	// load entry with random bits in the fields a load item ignores
	task automatic load_entry(logic [6:0] idx, logic [31:0] xb, logic [15:0] yb,
			logic [15:0] sl);
		send_item(FUNC_LOAD, $urandom, 1'($urandom_range(1)), idx, xb, yb, sl);
	endtask

	// Whole table with ascending masked bases; spacing 2**scale around zero.
	// Scale 25 spans the full 32-bit range.
	task automatic load_sorted_table(int scale);
		logic signed [31:0] xb;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			xb = ((i - 64) <<< scale) + ($urandom & ((32'd1 << scale) - 1));
			load_entry(7'(i), xb, 16'($urandom), 16'($urandom));
		end
	endtask

	// Wait out every expected result, then the pipeline depth, since
	// loads in flight produce nothing to wait on.
	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SEG_COUNT)
			sb.seg_count = data;
		else
			sb.out_width = data[1:0];
		@(posedge clk);
	endtask

	task automatic random_sample(output logic [31:0] smp);
		int k;
		case ($urandom_range(9))
			0, 1, 2: smp = $urandom;
			3: smp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: begin
				// near a segment edge, where the search decision flips
				k = $urandom_range(MAX_SEGMENTS - 1);
				smp = (sb.seg_x[k] & XBASE_MASK) + $urandom_range(512) - 256;
			end
		endcase
	endtask

	initial begin
		logic [31:0] smp;
		logic [7:0] count_pick [4] = '{8'd128, 8'd64, 8'd0, 8'd255};
		logic [1:0] width_pick [4] = '{OW_8, OW_16, OW_32, OW_WIDE};
		int scale_pick [4] = '{25, 12, 8, 20};

		sb = new();
		arst_n = 1'b0;
		sample_valid = 1'b0;
		func = FUNC_ACT;
		sample = '0;
		last_in = 1'b0;
		seg_index = '0;
		seg_xbase = '0;
		seg_ybase = '0;
		seg_slope = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SEG_COUNT;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		activations_sent = 0;
		loads_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill every entry first so no search ever reads an
		// unwritten one, then hit the reset config and the extremes.
		load_sorted_table(25);
		activate(32'h8000_0000);
		activate(32'h7FFF_FFFF);
		activate(32'h0);
		activate(32'hFFFF_FFFF);
		drain();
		write_reg(REG_SEG_COUNT, 8'd128);
		write_reg(REG_OUT_WIDTH, 8'(OW_8));
		smp = sb.seg_x[0] & XBASE_MASK;
		activate(smp);            // exactly on segment 0's base
		activate(smp - 1);
		activate(smp + 1);
		smp = sb.seg_x[77] & XBASE_MASK;
		activate(smp);
		activate(smp - 1);
		activate(32'h8000_0000);
		activate(32'h7FFF_FFFF);
		// steep segment 127 so the top clamps for sure
		load_entry(7'd127, 32'h7FFF_FF00, 16'h7FFF, 16'h7FFF);
		activate(32'h7FFF_FFFF);
		load_entry(7'd127, 32'h7FFF_FF03, 16'h8000, 16'h8000);
		activate(32'h7FFF_FFFF);

		// Random phases: idle mode cycles through no gaps, sender gaps,
		// receiver stalls, both at low rate.
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			write_reg(REG_SEG_COUNT, count_pick[ph]);
			write_reg(REG_OUT_WIDTH, 8'(width_pick[ph]));
			load_sorted_table(scale_pick[ph]);
			for (int n = 0; n < 100; n++) begin
				if (ph == 2 && n == 60) begin
					// sender holds until no result is still expected
					sample_valid <= 1'b0;
					do
						@(posedge clk);
					while (sb.pending.size() != 0);
				end
				if ($urandom_range(99) < 8) begin
					// noise: one entry overwritten, table may lose its order
					load_entry(7'($urandom), $urandom, 16'($urandom), 16'($urandom));
				end else begin
					random_sample(smp);
					activate(smp);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%t ERROR: %0d results never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		$display("Covered %0d activations and %0d table loads over 4 config/idle phases;",
			activations_sent, loads_sent);
		$display("%0d results checked, %0d of them clipped, %0d mismatches.",
			sb.results_seen, sb.sat_seen, sb.errors);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
